>>> rtl/pp_pkg.sv
// ----------------------------------------------------------------------------
// pp_pkg
// Shared sizes, codes and controller/datapath handshake structs for the
// page pool with reference counts.
// ----------------------------------------------------------------------------
`default_nettype none

package pp_pkg;

    // Pool geometry
    localparam int PAGES      = 65536;
    localparam int COUNT_BITS = 8;
    localparam int ADDR_W     = $clog2(PAGES);
    localparam int FILL_W     = $clog2(PAGES + 1);

    // Field widths on the channels
    localparam int OP_W       = 3;
    localparam int PAGE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_OUT_W = 8;
    localparam int LIMIT_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // Request operations
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_INC   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

    // Controller -> datapath commands
    typedef struct packed {
        logic clear_step;   // zero one count entry during the post-reset sweep
        logic accept;       // capture request and launch memory reads
        logic commit;       // write back state and load the result register
    } pp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic clear_last;   // sweep is at the last count entry
        logic out_free;     // result register can take a new result this cycle
    } pp_sts_t;

endpackage

`default_nettype wire

>>> rtl/pp_ifs.sv
// ----------------------------------------------------------------------------
// pp_ifs
// Valid/ready channel interfaces for requests and results of the page pool.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel
interface pp_req_if import pp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output operation, output page_number, input ready);
    modport sink   (input valid, input operation, input page_number, output ready);
endinterface

// Result channel
interface pp_rsp_if import pp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PAGE_W-1:0]      granted_page;
    logic [COUNT_OUT_W-1:0] count_value;
    logic                   returned_to_pool;

    modport source (output valid, output status, output granted_page,
                    output count_value, output returned_to_pool, input ready);
    modport sink   (input valid, input status, input granted_page,
                    input count_value, input returned_to_pool, output ready);
endinterface

`default_nettype wire

>>> rtl/pp_ctrl.sv
// ----------------------------------------------------------------------------
// pp_ctrl
// Sequencer: post-reset count clearing sweep, request capture, and commit
// once the result register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module pp_ctrl import pp_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire pp_sts_t sts,
    output pp_cmd_t      cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.accept     = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pp_dp.sv
// ----------------------------------------------------------------------------
// pp_dp
// Datapath: configuration registers, free-page stack memory, reference count
// memory, stack fill counter, request decode and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pp_dp import pp_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pp_cmd_t                cmd,
    output pp_sts_t                     sts,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // request payload
    input  wire logic [OP_W-1:0]        req_operation,
    input  wire logic [PAGE_W-1:0]      req_page_number,
    // result register
    input  wire logic                   rsp_ready,
    output logic                        rsp_valid,
    output logic [STATUS_W-1:0]         rsp_status,
    output logic [PAGE_W-1:0]           rsp_granted_page,
    output logic [COUNT_OUT_W-1:0]      rsp_count_value,
    output logic                        rsp_returned_to_pool
);

    // Memories
    logic [PAGE_W-1:0]     stack_mem [PAGES];
    logic [COUNT_BITS-1:0] count_mem [PAGES];

    logic [PAGE_W-1:0]      first_page_reg;
    logic [LIMIT_W-1:0]     page_limit_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [ADDR_W-1:0]      clear_addr_reg;
    logic [OP_W-1:0]        op_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [PAGE_W-1:0]      stack_rd_reg;
    logic [COUNT_BITS-1:0]  count_rd_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [PAGE_W-1:0]      out_granted_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_pushed_reg;

    logic [STATUS_W-1:0]    res_status;
    logic [PAGE_W-1:0]      res_granted;
    logic [COUNT_BITS-1:0]  res_count;
    logic                   res_pushed;
    logic                   do_pop;
    logic                   do_push;
    logic                   cnt_we;
    logic [COUNT_BITS-1:0]  cnt_wdata;
    logic                   page_bad;
    logic                   free_bad;
    logic                   stack_full;
    logic [ADDR_W-1:0]      page_addr;
    logic [ADDR_W-1:0]      cnt_addr;
    logic [COUNT_BITS-1:0]  cnt_mem_wdata;
    logic                   cnt_mem_we;

    assign sts.clear_last = (clear_addr_reg == ADDR_W'(PAGES - 1));
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            page_limit_reg <= LIMIT_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_PAGE: first_page_reg <= cfg_data[PAGE_W-1:0];
                CFG_PAGE_LIMIT: page_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= req_operation;
            page_reg <= req_page_number;
        end
    end

    // Range checks and decode of the captured request
    assign page_addr  = ADDR_W'(page_reg);
    assign page_bad   = (32'(page_reg) >= 32'(PAGES));
    assign free_bad   = (page_reg < first_page_reg) || (LIMIT_W'(page_reg) >= page_limit_reg);
    assign stack_full = (fill_reg == FILL_W'(PAGES));

    always_comb
    begin
        res_status  = STAT_OK;
        res_granted = '0;
        res_count   = '0;
        res_pushed  = 1'b0;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = count_rd_reg;
        priority if (op_reg == OP_ALLOC)
        begin
            if (fill_reg == '0)
            begin
                res_status = STAT_EMPTY;
            end
            else
            begin
                do_pop      = 1'b1;
                res_granted = stack_rd_reg;
            end
        end
        else if (op_reg > OP_READ)
        begin
            // unknown operation: all-zero result, no change
            res_status = STAT_OK;
        end
        else if (page_bad || (op_reg == OP_FREE && free_bad))
        begin
            res_status = STAT_RANGE;
        end
        else
        begin
            res_count = count_rd_reg;
            unique case (op_reg)
                OP_FREE:
                begin
                    if (count_rd_reg != '0)
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = count_rd_reg - 1'b1;
                        res_count = cnt_wdata;
                    end
                    else if (stack_full)
                    begin
                        res_status = STAT_LIMIT;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        res_pushed = 1'b1;
                    end
                end
                OP_INC:
                begin
                    if (&count_rd_reg)
                    begin
                        res_status = STAT_LIMIT;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = count_rd_reg + 1'b1;
                        res_count = cnt_wdata;
                    end
                end
                OP_DEC:
                begin
                    if (count_rd_reg == '0)
                    begin
                        res_status = STAT_LIMIT;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = count_rd_reg - 1'b1;
                        res_count = cnt_wdata;
                    end
                end
                default:
                begin
                    // read count
                    res_count = count_rd_reg;
                end
            endcase
        end
    end

    // Stack fill counter and clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (cmd.commit && do_pop)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
            else if (cmd.commit && do_push)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
        end
    end

    // Free-page stack: read top on accept, push on commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stack_rd_reg <= stack_mem[ADDR_W'(fill_reg - 1'b1)];
        end
        if (cmd.commit && do_push)
        begin
            stack_mem[ADDR_W'(fill_reg)] <= page_reg;
        end
    end

    // Count memory: single write port shared by the sweep and commits
    assign cnt_addr      = cmd.clear_step ? clear_addr_reg : page_addr;
    assign cnt_mem_wdata = cmd.clear_step ? '0 : cnt_wdata;
    assign cnt_mem_we    = cmd.clear_step || (cmd.commit && cnt_we);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            count_rd_reg <= count_mem[ADDR_W'(req_page_number)];
        end
        if (cnt_mem_we)
        begin
            count_mem[cnt_addr] <= cnt_mem_wdata;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg  <= res_status;
            out_granted_reg <= res_granted;
            out_count_reg   <= COUNT_OUT_W'(res_count);
            out_pushed_reg  <= res_pushed;
        end
    end

    assign rsp_valid            = out_valid_reg;
    assign rsp_status           = out_status_reg;
    assign rsp_granted_page     = out_granted_reg;
    assign rsp_count_value      = out_count_reg;
    assign rsp_returned_to_pool = out_pushed_reg;

endmodule

`default_nettype wire

>>> rtl/page_pool_with_ref_counts.sv
// ----------------------------------------------------------------------------
// page_pool_with_ref_counts
// Physical page pool: LIFO stack of free pages plus a per-page reference
// count, one request at a time.
//
//   Channel   Dir  Handshake        Payload
//   req       in   valid/ready      operation, page_number
//   rsp       out  valid/ready      status, granted_page, count_value,
//                                   returned_to_pool
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// Each request runs through S_IDLE, which accepts it and reads the count and
// stack memories, then S_EXEC, which does the read-modify-write and loads
// the result; no new request is taken until that commit has happened.
// After reset, req.ready stays low while the count memory is swept to
// zero; configuration writes are taken during the sweep.
// A full result register holds the commit until rsp.ready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module page_pool_with_ref_counts import pp_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pp_req_if.sink                     req,
    pp_rsp_if.source                   rsp
);

    pp_cmd_t cmd;
    pp_sts_t sts;

    // Sequencer
    pp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and decode
    pp_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .req_operation        (req.operation),
        .req_page_number      (req.page_number),
        .rsp_ready            (rsp.ready),
        .rsp_valid            (rsp.valid),
        .rsp_status           (rsp.status),
        .rsp_granted_page     (rsp.granted_page),
        .rsp_count_value      (rsp.count_value),
        .rsp_returned_to_pool (rsp.returned_to_pool)
    );

endmodule

`default_nettype wire
